// ----- rtl/gpp_pkg.sv -----
package gpp_pkg;

	localparam int GRID_SIZE_DEF = 64;

	localparam int CELL_W = 2;
	localparam int POS_OUT_W = 6;

	localparam logic [CELL_W-1:0] CELL_BLANK = 2'd0;
	localparam logic [CELL_W-1:0] CELL_STAR  = 2'd1;
	localparam logic [CELL_W-1:0] CELL_HASH  = 2'd2;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] HEAD_NORTH = 2'd0;
	localparam logic [1:0] HEAD_SOUTH = 2'd1;
	localparam logic [1:0] HEAD_WEST  = 2'd2;
	localparam logic [1:0] HEAD_EAST  = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MOVE,
		ST_DONE
	} gpp_state_t;

	// Lowest field in the lowest bits, matching the stream packing.
	typedef struct packed {
		logic [5:0] read_col;
		logic [5:0] read_row;
		logic       bold;
		logic [7:0] step_count;
		logic [1:0] heading;
		logic       pen_down;
		logic       opcode;
	} gpp_cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0]    cell_value;
		logic [POS_OUT_W-1:0] pen_col_out;
		logic [POS_OUT_W-1:0] pen_row_out;
		logic                 move_accepted;
	} gpp_res_t;

endpackage

// ----- rtl/gpp_ram.sv -----
module gpp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/gpp_ctrl.sv -----
module gpp_ctrl
	import gpp_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	localparam int CW = $clog2(GRID_SIZE),
	localparam int AW = 2 * CW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  gpp_cmd_t          cmd,
	output logic              ready,
	output logic              res_valid,
	output gpp_res_t          res,
	input  logic              res_take,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [CELL_W-1:0] ram_wdata,
	output logic [AW-1:0]     ram_raddr,
	input  logic [CELL_W-1:0] ram_rdata
);

	localparam int CMPW = ((CW > 8) ? CW : 8) + 1;
	localparam logic [CMPW-1:0] LAST_E = CMPW'(GRID_SIZE - 1);

	gpp_state_t state_q, state_n;

	logic [AW-1:0]     clr_q;
	logic [CW-1:0]     pen_row_q, pen_col_q;
	logic [CW-1:0]     cur_row_q, cur_col_q;
	logic [CW-1:0]     cur_row_nxt, cur_col_nxt;
	logic [7:0]        cnt_q;
	logic [1:0]        hdg_q;
	logic              bold_q;
	logic              in_range_q;
	logic              acc_q;
	logic [CELL_W-1:0] cell_q;

	logic              wr_vld_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic              wr_bold_s1;

	logic              start;
	logic              move_ok;
	logic              in_range;
	logic [CMPW-1:0]   row_e, col_e, st_e;
	logic [CW-1:0]     fin_row, fin_col;

	assign start = cmd_valid && ready;
	assign row_e = CMPW'(pen_row_q);
	assign col_e = CMPW'(pen_col_q);
	assign st_e  = CMPW'(cmd.step_count);
	assign in_range = (32'(cmd.read_row) < GRID_SIZE) && (32'(cmd.read_col) < GRID_SIZE);

	// Bounds check and final position of a draw move.
	always_comb begin
		move_ok = 1'b0;
		fin_row = pen_row_q;
		fin_col = pen_col_q;
		case (cmd.heading)
			HEAD_NORTH: begin
				move_ok = st_e <= row_e;
				fin_row = CW'(row_e - st_e);
			end
			HEAD_SOUTH: begin
				move_ok = (row_e + st_e) <= LAST_E;
				fin_row = CW'(row_e + st_e);
			end
			HEAD_WEST: begin
				move_ok = st_e <= col_e;
				fin_col = CW'(col_e - st_e);
			end
			default: begin
				move_ok = (col_e + st_e) <= LAST_E;
				fin_col = CW'(col_e + st_e);
			end
		endcase
	end

	always_comb begin
		cur_row_nxt = cur_row_q;
		cur_col_nxt = cur_col_q;
		case (hdg_q)
			HEAD_NORTH: cur_row_nxt = cur_row_q - 1'b1;
			HEAD_SOUTH: cur_row_nxt = cur_row_q + 1'b1;
			HEAD_WEST:  cur_col_nxt = cur_col_q - 1'b1;
			default:    cur_col_nxt = cur_col_q + 1'b1;
		endcase
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) state_n = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					if (cmd.opcode == OP_READ) begin
						state_n = ST_READ;
					end else if (move_ok && cmd.pen_down && cmd.step_count != 8'd0) begin
						state_n = ST_MOVE;
					end else begin
						state_n = ST_DONE;
					end
				end
			end
			ST_READ: state_n = ST_DONE;
			ST_MOVE: begin
				if (cnt_q == 8'd1) state_n = ST_DONE;
			end
			ST_DONE: begin
				if (res_take) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		ready     = 1'b0;
		res_valid = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_CLEAR: ram_raddr = '0;
			ST_IDLE: begin
				ready     = 1'b1;
				ram_raddr = {CW'(cmd.read_row), CW'(cmd.read_col)};
			end
			ST_READ: ram_raddr = '0;
			ST_MOVE: ram_raddr = {cur_row_nxt, cur_col_nxt};
			ST_DONE: res_valid = 1'b1;
			default: ram_raddr = '0;
		endcase
	end

	// Write side: sweep during clear, else finish the mark read last cycle.
	always_comb begin
		ram_we    = (state_q == ST_CLEAR) || wr_vld_s1;
		ram_waddr = (state_q == ST_CLEAR) ? clr_q : wr_addr_s1;
		if (state_q == ST_CLEAR) begin
			ram_wdata = CELL_BLANK;
		end else if (wr_bold_s1 || ram_rdata == CELL_HASH) begin
			ram_wdata = CELL_HASH;
		end else begin
			ram_wdata = CELL_STAR;
		end
	end

	assign res = '{
		cell_value:    cell_q,
		pen_col_out:   POS_OUT_W'(pen_col_q),
		pen_row_out:   POS_OUT_W'(pen_row_q),
		move_accepted: acc_q
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			pen_row_q <= '0;
			pen_col_q <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (start && cmd.opcode == OP_DRAW && move_ok) begin
				pen_row_q <= fin_row;
				pen_col_q <= fin_col;
			end
			wr_vld_s1 <= (state_q == ST_MOVE);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_row_q  <= pen_row_q;
			cur_col_q  <= pen_col_q;
			cnt_q      <= cmd.step_count;
			hdg_q      <= cmd.heading;
			bold_q     <= cmd.bold;
			in_range_q <= in_range;
			acc_q      <= (cmd.opcode == OP_DRAW) && move_ok;
			cell_q     <= CELL_BLANK;
		end
		if (state_q == ST_READ) begin
			cell_q <= in_range_q ? ram_rdata : CELL_BLANK;
		end
		if (state_q == ST_MOVE) begin
			cur_row_q <= cur_row_nxt;
			cur_col_q <= cur_col_nxt;
			cnt_q     <= cnt_q - 1'b1;
		end
		wr_addr_s1 <= {cur_row_nxt, cur_col_nxt};
		wr_bold_s1 <= bold_q;
	end

endmodule

// ----- rtl/grid_pen_plotter.sv -----
// Channel   Dir  Bits  Contents
// s_axis    in   32    command: opcode, pen_down, heading, step_count, bold, read_row, read_col
// m_axis    out  16    result: move_accepted, pen_row_out, pen_col_out, cell_value
//
// One item at a time. A marking draw does one canvas read-modify-write per cell through
// the single RAM write port; a draw with the pen up, a rejected move or a zero-step move
// writes nothing to the canvas.
// After reset a clearing pass writes all 2**(2*clog2(GRID_SIZE)) canvas entries
// (4096 at the default size), with s_axis_tready low.
// The result register frees the sequencer, so the next command can be taken while a
// result waits on m_axis_tready.
module grid_pen_plotter
	import gpp_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] opcode, [1] pen_down, [3:2] heading, [11:4] step_count, [12] bold,
	// [18:13] read_row, [24:19] read_col, [31:25] zero
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] move_accepted, [6:1] pen_row_out, [12:7] pen_col_out, [14:13] cell_value,
	// [15] zero
	output logic [15:0] m_axis_tdata
);

	localparam int CW = $clog2(GRID_SIZE);
	localparam int AW = 2 * CW;

	gpp_cmd_t          cmd;
	gpp_res_t          res;
	gpp_res_t          m_res_q;
	logic              m_vld_q;
	logic              res_valid;
	logic              res_take;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	assign cmd = s_axis_tdata[$bits(gpp_cmd_t)-1:0];

	gpp_ctrl #(
		.GRID_SIZE(GRID_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_axis_tvalid),
		.cmd       (cmd),
		.ready     (s_axis_tready),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	gpp_ram #(
		.WIDTH(CELL_W),
		.DEPTH(2 ** AW)
	) u_canvas (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Load the result register when it is empty or being drained this cycle.
	assign res_take = res_valid && (!m_vld_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (res_take) begin
			m_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {1'b0, m_res_q};

endmodule

// ----- rtl/gpp_checker.sv -----
module gpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	logic        in_xfer, out_xfer;
	logic [1:0]  pend_q;
	logic [11:0] last_pen_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 2'd0;
			last_pen_q <= '0;
		end else begin
			if (in_xfer && !out_xfer) begin
				pend_q <= pend_q + 2'd1;
			end else if (out_xfer && !in_xfer) begin
				pend_q <= pend_q - 2'd1;
			end
			if (out_xfer) begin
				last_pen_q <= m_axis_tdata[12:1];
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (pend_q != 2'd0))
		else $error("result without a command");

	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("too many commands in flight");

	a_pen_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !m_axis_tdata[0] |-> (m_axis_tdata[12:1] == last_pen_q))
		else $error("pen moved on a read or rejected move");

endmodule

bind grid_pen_plotter gpp_checker u_gpp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
